[design/pba_pkg.sv]
// Package for the page bitmap allocator: widths, codes, the token that
// travels down the cell chain and the first-zero search.
// No dependencies.
package pba_pkg;

  localparam int PAGE_W           = 10;
  localparam int WORD_BITS        = 64;
  localparam int BIT_IDX_W        = 6;
  localparam int WORD_IDX_W       = PAGE_W - BIT_IDX_W;
  localparam int MAX_WORDS        = 1 << WORD_IDX_W;
  localparam int BITMAP_WORDS_DEF = 16;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [PAGE_W-1:0] page;
    status_t           status;
    logic              done;
  } tok_t;

  // Position, counted from the most significant end, of the first clear bit.
  function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] v);
    logic [2:0] grp;
    logic [2:0] bpos;
    logic [7:0] grp_bits;
    grp  = '0;
    bpos = '0;
    for (int g = 7; g >= 0; g--) begin
      if (v[{~3'(g), 3'b111} -: 8] != 8'hFF) begin
        grp = 3'(g);
      end
    end
    grp_bits = v[{~grp, 3'b111} -: 8];
    for (int b = 7; b >= 0; b--) begin
      if (!grp_bits[~3'(b)]) begin
        bpos = 3'(b);
      end
    end
    return {grp, bpos};
  endfunction

endpackage

[design/pba_if.sv]
// Handshake channels of the page bitmap allocator: request and result.
// Depends on pba_pkg.
interface pba_in_if;
  import pba_pkg::*;
  logic              valid;
  logic              ready;
  logic [0:0]        command;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, command, page_number, input ready);
  modport sink   (input valid, command, page_number, output ready);
endinterface

interface pba_out_if;
  import pba_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] granted_page;
  logic [1:0]        status;

  modport source (output valid, granted_page, status, input ready);
  modport sink   (input valid, granted_page, status, output ready);
endinterface

[design/pba_cell.sv]
// One cell of the allocator chain: holds one 64-bit bitmap word and
// serves the token passing through it. Depends on pba_pkg.
module pba_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  pba_pkg::tok_t tok_in,
  output pba_pkg::tok_t tok_out
);
  import pba_pkg::*;

  logic [WORD_BITS-1:0] word_r, word_nxt;
  tok_t                 tok_r, tok_nxt;
  logic [BIT_IDX_W-1:0] pos;

  assign pos = first_zero(word_r);

  always_comb begin
    word_nxt = word_r;
    tok_nxt  = tok_in;
    if (tok_in.vld) begin
      if (tok_in.cmd == CMD_ALLOC && !tok_in.done && word_r != '1) begin
        word_nxt[~pos]  = 1'b1;
        tok_nxt.page    = {WORD_IDX_W'(IDX), pos};
        tok_nxt.status  = ST_OK;
        tok_nxt.done    = 1'b1;
      end
      if (tok_in.cmd == CMD_FREE && tok_in.status == ST_OK &&
          tok_in.page[PAGE_W-1:BIT_IDX_W] == WORD_IDX_W'(IDX)) begin
        word_nxt[~tok_in.page[BIT_IDX_W-1:0]] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r    <= '0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      word_r <= word_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

[design/page_bitmap_allocator.sv]
// Page bitmap allocator. Pages live in a row of cells, one 64-bit word
// per cell, all free after reset. Every request beat walks the chain one
// cell per cycle while the result side does not stall, through the cells
// (BITMAP_WORDS, capped at 16 cells, the pages a 10-bit number can name)
// and then the result register; requests follow one another every cycle
// unless the result side stalls, so a new beat is taken while earlier ones
// are still in the chain. A stall on the result side freezes the whole
// chain. Depends on pba_pkg, pba_if and pba_cell.
module page_bitmap_allocator #(
  parameter int BITMAP_WORDS = pba_pkg::BITMAP_WORDS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pba_in_if.sink   in_ch,
  pba_out_if.source out_ch
);
  import pba_pkg::*;

  localparam int ACTIVE_WORDS = (BITMAP_WORDS > MAX_WORDS) ? MAX_WORDS : BITMAP_WORDS;
  localparam int TOTAL_PAGES  = BITMAP_WORDS * WORD_BITS;

  tok_t              tok [ACTIVE_WORDS+1];
  logic              adv;
  logic              in_range;
  logic              out_valid_r;
  logic [PAGE_W-1:0] out_page_r;
  status_t           out_status_r;
  tok_t              tok_last;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_range    = {22'd0, in_ch.page_number} < 32'(TOTAL_PAGES);

  always_comb begin
    tok[0].vld  = in_ch.valid;
    tok[0].cmd  = cmd_t'(in_ch.command);
    tok[0].done = 1'b0;
    if (cmd_t'(in_ch.command) == CMD_ALLOC) begin
      tok[0].page   = '0;
      tok[0].status = ST_FULL;
    end else begin
      tok[0].page   = in_ch.page_number;
      tok[0].status = in_range ? ST_OK : ST_RANGE;
    end
  end

  for (genvar i = 0; i < ACTIVE_WORDS; i++) begin : g_cell
    pba_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tok_last = tok[ACTIVE_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok_last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_page_r   <= (tok_last.cmd == CMD_ALLOC) ? tok_last.page : '0;
      out_status_r <= tok_last.status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_page = out_page_r;
  assign out_ch.status       = out_status_r;

  a_page_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_page_r == '0)
    else $error("granted page nonzero on a failed request");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tok_last) && $stable(out_page_r))
    else $error("chain moved while result stalled");

  a_range_only_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_RANGE |-> TOTAL_PAGES < (1 << PAGE_W))
    else $error("range error reported for a full-size bitmap");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
